/* src/assert_macros.svh */
// Assertion macros for the validator RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* src/ialv_pkg.sv */
// Types, constants and checker step functions for the IP literal validator.
// Depends on nothing; used by every module of the block.
package ialv_pkg;

  // Character codes
  localparam logic [15:0] CH_0     = 16'h0030;
  localparam logic [15:0] CH_9     = 16'h0039;
  localparam logic [15:0] CH_LA    = 16'h0061;
  localparam logic [15:0] CH_LF    = 16'h0066;
  localparam logic [15:0] CH_UA    = 16'h0041;
  localparam logic [15:0] CH_UF    = 16'h0046;
  localparam logic [15:0] CH_DOT   = 16'h002E;
  localparam logic [15:0] CH_COLON = 16'h003A;

  // Dotted-quad limits
  localparam logic [2:0] QUAD_OCTETS = 3'd4;
  localparam logic [1:0] QUAD_DIGITS = 2'd3;
  localparam logic [9:0] OCTET_MAX   = 10'd255;

  // Colon-hextet limits
  localparam logic [3:0] HEX_GROUPS = 4'd8;
  localparam logic [3:0] HEX_V4_AT  = 4'd6;
  localparam logic [2:0] HEX_DIGITS = 3'd4;
  localparam logic [2:0] HEX_SAT    = 3'd5;

  // Token queue geometry
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_of_host;
  } in_t;

  typedef struct packed {
    logic is_ip_address;
    logic is_ipv6_form;
  } out_t;

  // Classified code unit passed from front to back
  typedef struct packed {
    logic [3:0] digit;
    logic       is_digit;
    logic       is_hex;
    logic       is_dot;
    logic       is_colon;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    CS_NONE,
    CS_WILL_SKIP,
    CS_SKIPPING,
    CS_SKIPPED,
    CS_FINAL
  } cs_t;

  typedef struct packed {
    logic [2:0] count;
    logic [1:0] len;
    logic [9:0] value;
    logic       lz;
    logic       failed;
  } quad_t;

  typedef struct packed {
    cs_t        cs;
    logic [3:0] count;
    logic [2:0] length;
    logic       all_hex;
    logic       failed;
    quad_t      eq;
  } hex_t;

  localparam quad_t QUAD_RST = '{count: 3'd0, len: 2'd0, value: 10'd0, lz: 1'b0,
                                 failed: 1'b0};
  localparam hex_t  HEX_RST  = '{cs: CS_NONE, count: 4'd0, length: 3'd0, all_hex: 1'b1,
                                 failed: 1'b0, eq: QUAD_RST};

  // Close the current octet
  function automatic quad_t quad_close(quad_t q);
    quad_t r;
    r = q;
    if (q.count >= QUAD_OCTETS || q.len == 2'd0 || q.value > OCTET_MAX ||
        (q.lz && q.len > 2'd1)) begin
      r.failed = 1'b1;
    end else begin
      r.count = q.count + 3'd1;
    end
    r.len   = 2'd0;
    r.value = 10'd0;
    r.lz    = 1'b0;
    return r;
  endfunction

  // Feed one character to a dotted-quad checker
  function automatic quad_t quad_char(quad_t q, tok_t t);
    quad_t r;
    r = q;
    if (t.is_dot) begin
      r = quad_close(q);
    end else if (q.len >= QUAD_DIGITS || !t.is_digit) begin
      r.failed = 1'b1;
    end else begin
      if (q.len == 2'd0 && t.digit == 4'd0) begin
        r.lz = 1'b1;
      end
      r.value = 10'(q.value * 10'd10) + 10'(t.digit);
      r.len   = q.len + 2'd1;
    end
    return r;
  endfunction

  function automatic logic quad_ok(quad_t q);
    return !q.failed && q.count == QUAD_OCTETS;
  endfunction

  // Close the current hextet at a colon or at the end of the host
  function automatic hex_t hextet_close(hex_t h);
    hex_t  r;
    quad_t eq;
    r  = h;
    eq = h.eq;
    if (h.count >= HEX_GROUPS || h.cs == CS_FINAL) begin
      r.failed = 1'b1;
    end else if (h.length == 3'd0) begin
      case (h.cs)
        CS_SKIPPED:   r.failed = 1'b1;
        CS_NONE:      r.cs = (h.count == 4'd0) ? CS_WILL_SKIP : CS_SKIPPING;
        CS_WILL_SKIP: r.cs = CS_SKIPPING;
        default:      r.cs = CS_FINAL;
      endcase
    end else if (h.cs == CS_WILL_SKIP) begin
      r.failed = 1'b1;
    end else begin
      if (h.cs == CS_SKIPPING) begin
        r.cs = CS_SKIPPED;
      end
      if (h.length > HEX_DIGITS) begin
        // too long for a hextet: only an embedded dotted quad may stand here
        eq = quad_close(h.eq);
        if ((r.cs == CS_NONE && h.count != HEX_V4_AT) ||
            (r.cs == CS_SKIPPED && h.count >= HEX_V4_AT) || !quad_ok(eq)) begin
          r.failed = 1'b1;
        end
        r.cs = CS_FINAL;
      end else if (!h.all_hex) begin
        r.failed = 1'b1;
      end else begin
        r.count = h.count + 4'd1;
      end
    end
    r.length  = 3'd0;
    r.all_hex = 1'b1;
    r.eq      = QUAD_RST;
    return r;
  endfunction

  function automatic logic hextet_ok(hex_t h);
    logic ok;
    ok = 1'b0;
    if (!h.failed) begin
      case (h.cs)
        CS_NONE:    ok = (h.count == HEX_GROUPS);
        CS_SKIPPED: ok = (h.count < HEX_GROUPS);
        CS_FINAL:   ok = 1'b1;
        default:    ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

endpackage

/* src/ialv_front.sv */
// Front end: accepts input transactions and classifies each code unit.
// Depends on ialv_pkg; feeds the token queue.
module ialv_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  ialv_pkg::in_t   in_data,
  input  ialv_pkg::q_stat_t q_stat,
  output logic            push,
  output ialv_pkg::tok_t  tok
);

  // Hold the input while the queue is full
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Classify the code unit
  always_comb begin
    tok          = '0;
    tok.is_digit = in_data.code_unit inside {[ialv_pkg::CH_0:ialv_pkg::CH_9]};
    tok.is_hex   = in_data.code_unit inside {[ialv_pkg::CH_0:ialv_pkg::CH_9],
                                             [ialv_pkg::CH_LA:ialv_pkg::CH_LF],
                                             [ialv_pkg::CH_UA:ialv_pkg::CH_UF]};
    tok.is_dot   = (in_data.code_unit == ialv_pkg::CH_DOT);
    tok.is_colon = (in_data.code_unit == ialv_pkg::CH_COLON);
    tok.digit    = in_data.code_unit[3:0];
    tok.last     = in_data.last_of_host;
  end

endmodule

/* src/ialv_queue.sv */
// Short token queue between the classifying front end and the checker.
// Depends on ialv_pkg.
module ialv_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ialv_pkg::tok_t    push_tok,
  input  logic              pop,
  output ialv_pkg::tok_t    pop_tok,
  output ialv_pkg::q_stat_t q_stat
);

  ialv_pkg::tok_t            entry_r [ialv_pkg::Q_DEPTH];
  logic [ialv_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ialv_pkg::Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ialv_pkg::Q_AW:0]   count_r, count_nxt;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + ialv_pkg::Q_AW'(push);
    rd_ptr_nxt = rd_ptr_r + ialv_pkg::Q_AW'(pop);
    count_nxt  = count_r + (ialv_pkg::Q_AW+1)'(push) - (ialv_pkg::Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed tokens
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_tok;
    end
  end

  assign pop_tok      = entry_r[rd_ptr_r];
  assign q_stat.full  = (count_r == (ialv_pkg::Q_AW+1)'(ialv_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

/* src/ialv_checker.sv */
// Back end: runs the dotted-quad and colon-hextet checkers on each token
// and registers the verdict. Depends on ialv_pkg.
module ialv_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  ialv_pkg::q_stat_t q_stat,
  input  ialv_pkg::tok_t    tok,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output ialv_pkg::out_t    out_data
);

  logic                colon_r, colon_nxt;
  ialv_pkg::quad_t     top_r, top_nxt;
  ialv_pkg::hex_t      hex_r, hex_nxt;
  logic                out_valid_r, out_valid_nxt;
  ialv_pkg::out_t      out_data_r, out_data_nxt;
  ialv_pkg::quad_t     top_step, top_end;
  ialv_pkg::hex_t      hex_step, hex_end;
  logic                colon_step;
  logic                slot_free;

  // Take a token when one waits; a closing token also needs the output slot
  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = !q_stat.empty && (!tok.last || slot_free);

  // Step both checkers by one character
  always_comb begin
    top_step   = ialv_pkg::quad_char(top_r, tok);
    colon_step = colon_r;
    hex_step   = hex_r;
    if (tok.is_colon) begin
      colon_step = 1'b1;
      hex_step   = ialv_pkg::hextet_close(hex_r);
    end else begin
      if (hex_r.length < ialv_pkg::HEX_SAT) begin
        hex_step.length = hex_r.length + 3'd1;
      end
      if (!tok.is_hex) begin
        hex_step.all_hex = 1'b0;
      end
      hex_step.eq = ialv_pkg::quad_char(hex_r.eq, tok);
    end
    top_end = ialv_pkg::quad_close(top_step);
    hex_end = ialv_pkg::hextet_close(hex_step);
  end

  // Advance checker state; restart after the end of a host
  always_comb begin
    colon_nxt = colon_r;
    top_nxt   = top_r;
    hex_nxt   = hex_r;
    if (pop) begin
      if (tok.last) begin
        colon_nxt = 1'b0;
        top_nxt   = ialv_pkg::QUAD_RST;
        hex_nxt   = ialv_pkg::HEX_RST;
      end else begin
        colon_nxt = colon_step;
        top_nxt   = top_step;
        hex_nxt   = hex_step;
      end
    end
  end

  // Load the verdict into the output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (pop && tok.last) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.is_ipv6_form  = colon_step;
      out_data_nxt.is_ip_address = colon_step ? ialv_pkg::hextet_ok(hex_end)
                                              : ialv_pkg::quad_ok(top_end);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colon_r     <= 1'b0;
      top_r       <= ialv_pkg::QUAD_RST;
      hex_r       <= ialv_pkg::HEX_RST;
      out_valid_r <= 1'b0;
    end else begin
      colon_r     <= colon_nxt;
      top_r       <= top_nxt;
      hex_r       <= hex_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/ip_address_literal_validator_top.sv */
// IP literal validator: one code unit per transaction, verdict on the last one.
// An accepted code unit is written into the token queue; the checker pops it and,
// for the last code unit of a host, registers the verdict.
// Throughput: one code unit per cycle unless the queue is full or a verdict stalls.
// Reset (rst_n low, synchronous) empties the queue, clears the output and
// returns both checkers to their start state.
`include "assert_macros.svh"

module ip_address_literal_validator_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ialv_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ialv_pkg::out_t out_data
);

  ialv_pkg::q_stat_t q_stat;
  ialv_pkg::tok_t    push_tok;
  ialv_pkg::tok_t    pop_tok;
  logic              push;
  logic              pop;

  // Accept and classify
  ialv_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .tok      (push_tok)
  );

  // Decouple front and back
  ialv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .pop_tok  (pop_tok),
    .q_stat   (q_stat)
  );

  // Check and report
  ialv_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .tok       (pop_tok),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Checks on the internal queue and verdict path
  `ASSERT_CLK(a_pop_needs_token, clk, rst_n, pop |-> !q_stat.empty, "pop from empty queue")
  `ASSERT_NEVER(a_full_and_empty, clk, rst_n, q_stat.full && q_stat.empty, "queue full and empty")
  `ASSERT_CLK(a_verdict_source, clk, rst_n, $rose(out_valid) |-> $past(pop && pop_tok.last), "verdict without closing token")

endmodule

/* test/tb.sv */
// Self-checking testbench for ip_address_literal_validator_top: directed and random host strings.
// Depends on ialv_pkg and the validator RTL. A bit-level predictor of both checkers builds the
// expected verdict for every host, and a scoreboard process compares it with the block's output.
module tb;

  // Predictor limits, taken from the address grammar
  localparam logic [9:0] OCTET_TOP        = 10'd255;
  localparam logic [2:0] OCTETS_PER_QUAD  = 3'd4;
  localparam logic [1:0] MAX_OCTET_DIGITS = 2'd3;
  localparam logic [3:0] MAX_GROUPS       = 4'd8;
  localparam logic [3:0] QUAD_TAIL_AT     = 4'd6;
  localparam logic [2:0] MAX_GROUP_DIGITS = 3'd4;
  localparam logic [2:0] GROUP_LEN_CAP    = 3'd5;
  localparam int unsigned QUIET_LIMIT     = 2000;

  typedef struct packed {
    logic [2:0] octets;
    logic [1:0] digits;
    logic [9:0] val;
    logic       zero_first;
    logic       bad;
  } dotted_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  ialv_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  ialv_pkg::out_t out_data;

  // Predictor state
  logic          saw_colon;
  dotted_t       plain_quad;
  dotted_t       tail_quad;
  ialv_pkg::cs_t skip_phase;
  logic [3:0]    group_count;
  logic [2:0]    group_len;
  logic          group_hex;
  logic          groups_bad;

  ialv_pkg::out_t verdicts_due[$];
  logic [15:0] host_buf[$];
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit sender_calm = 1'b0;
  bit sink_calm = 1'b0;

  ip_address_literal_validator_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic dotted_t dq_end_octet(dotted_t q);
    dotted_t r;
    r = q;
    if (q.octets >= OCTETS_PER_QUAD || q.digits == 2'd0 || q.val > OCTET_TOP ||
        (q.zero_first && q.digits > 2'd1)) begin
      r.bad = 1'b1;
    end else begin
      r.octets = q.octets + 3'd1;
    end
    r.digits     = 2'd0;
    r.val        = 10'd0;
    r.zero_first = 1'b0;
    return r;
  endfunction

  function automatic dotted_t dq_feed(dotted_t q, logic [15:0] c);
    dotted_t r;
    int      v;
    r = q;
    if (c == ialv_pkg::CH_DOT) begin
      r = dq_end_octet(q);
    end else if (q.digits >= MAX_OCTET_DIGITS || c < ialv_pkg::CH_0 ||
                 c > ialv_pkg::CH_9) begin
      r.bad = 1'b1;
    end else begin
      if (q.digits == 2'd0 && c == ialv_pkg::CH_0) begin
        r.zero_first = 1'b1;
      end
      v = int'(q.val) * 10 + int'(c - ialv_pkg::CH_0);
      r.val    = v[9:0];
      r.digits = q.digits + 2'd1;
    end
    return r;
  endfunction

  function automatic logic dq_complete(dotted_t q);
    return !q.bad && q.octets == OCTETS_PER_QUAD;
  endfunction

  function automatic logic hex_char(logic [15:0] c);
    return (c >= ialv_pkg::CH_0 && c <= ialv_pkg::CH_9) ||
           (c >= ialv_pkg::CH_LA && c <= ialv_pkg::CH_LF) ||
           (c >= ialv_pkg::CH_UA && c <= ialv_pkg::CH_UF);
  endfunction

  function automatic void reset_tracking();
    saw_colon   = 1'b0;
    plain_quad  = '0;
    tail_quad   = '0;
    skip_phase  = ialv_pkg::CS_NONE;
    group_count = 4'd0;
    group_len   = 3'd0;
    group_hex   = 1'b1;
    groups_bad  = 1'b0;
  endfunction

  // Close one colon-separated group, at a colon or at the end of the host
  function automatic void close_group();
    dotted_t q;
    if (group_count >= MAX_GROUPS || skip_phase == ialv_pkg::CS_FINAL) begin
      groups_bad = 1'b1;
    end else if (group_len == 3'd0) begin
      case (skip_phase)
        ialv_pkg::CS_SKIPPED:   groups_bad = 1'b1;
        ialv_pkg::CS_NONE:      skip_phase = (group_count == 4'd0) ? ialv_pkg::CS_WILL_SKIP
                                                                   : ialv_pkg::CS_SKIPPING;
        ialv_pkg::CS_WILL_SKIP: skip_phase = ialv_pkg::CS_SKIPPING;
        default:                skip_phase = ialv_pkg::CS_FINAL;
      endcase
    end else if (skip_phase == ialv_pkg::CS_WILL_SKIP) begin
      groups_bad = 1'b1;
    end else begin
      if (skip_phase == ialv_pkg::CS_SKIPPING) begin
        skip_phase = ialv_pkg::CS_SKIPPED;
      end
      if (group_len > MAX_GROUP_DIGITS) begin
        // overlong group: acceptable only as a trailing dotted quad
        q = dq_end_octet(tail_quad);
        if ((skip_phase == ialv_pkg::CS_NONE && group_count != QUAD_TAIL_AT) ||
            (skip_phase == ialv_pkg::CS_SKIPPED && group_count >= QUAD_TAIL_AT) ||
            !dq_complete(q)) begin
          groups_bad = 1'b1;
        end
        skip_phase = ialv_pkg::CS_FINAL;
      end else if (!group_hex) begin
        groups_bad = 1'b1;
      end else begin
        group_count = group_count + 4'd1;
      end
    end
    group_len = 3'd0;
    group_hex = 1'b1;
    tail_quad = '0;
  endfunction

  function automatic logic groups_accept();
    logic ok;
    ok = 1'b0;
    if (!groups_bad) begin
      case (skip_phase)
        ialv_pkg::CS_NONE:    ok = (group_count == MAX_GROUPS);
        ialv_pkg::CS_SKIPPED: ok = (group_count < MAX_GROUPS);
        ialv_pkg::CS_FINAL:   ok = 1'b1;
        default:              ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

  // Advance both checkers by one code unit; return 1 when a verdict is due
  function automatic bit predict_unit(input ialv_pkg::in_t item,
                                      output ialv_pkg::out_t verdict);
    logic [15:0] c;
    bit          due;
    c       = item.code_unit;
    verdict = '0;
    due     = 1'b0;
    plain_quad = dq_feed(plain_quad, c);
    if (c == ialv_pkg::CH_COLON) begin
      saw_colon = 1'b1;
      close_group();
    end else begin
      if (group_len < GROUP_LEN_CAP) begin
        group_len = group_len + 3'd1;
      end
      if (!hex_char(c)) begin
        group_hex = 1'b0;
      end
      tail_quad = dq_feed(tail_quad, c);
    end
    if (item.last_of_host) begin
      plain_quad = dq_end_octet(plain_quad);
      close_group();
      verdict.is_ipv6_form  = saw_colon;
      verdict.is_ip_address = saw_colon ? groups_accept() : dq_complete(plain_quad);
      reset_tracking();
      due = 1'b1;
    end
    return due;
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 85) return $urandom_range(1, 3);
    else if (roll < 97) return $urandom_range(4, 8);
    else return $urandom_range(10, 40);
  endfunction

  // Offer one code unit, hold it until accepted, then idle for a random gap
  task automatic send_unit(input ialv_pkg::in_t item);
    ialv_pkg::out_t verdict;
    int unsigned    gap;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_unit(item, verdict)) begin
      verdicts_due.push_back(verdict);
    end
    gap = sender_calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_host();
    ialv_pkg::in_t item;
    for (int i = 0; i < host_buf.size(); i++) begin
      item.code_unit    = host_buf[i];
      item.last_of_host = (i == host_buf.size() - 1);
      send_unit(item);
    end
  endtask

  // Drop valid and hold off until every outstanding verdict has arrived
  task automatic drain_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      host_buf.push_back({8'h00, s[i]});
    end
  endfunction

  task automatic send_text(string s);
    host_buf.delete();
    push_text(s);
    send_host();
  endtask

  // ---------------------------------------------------------------- random hosts

  function automatic logic [15:0] hex_digit_char(int unsigned idx);
    if (idx < 10) return ialv_pkg::CH_0 + 16'(idx);
    else if (idx < 16) return ialv_pkg::CH_LA + 16'(idx - 10);
    else return ialv_pkg::CH_UA + 16'(idx - 16);
  endfunction

  function automatic logic [15:0] noise_char();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return ialv_pkg::CH_0 + 16'($urandom_range(0, 9));
    else if (roll < 45) return hex_digit_char($urandom_range(10, 21));
    else if (roll < 65) return ialv_pkg::CH_COLON;
    else if (roll < 80) return ialv_pkg::CH_DOT;
    else return 16'($urandom_range(0, 65535));
  endfunction

  function automatic void add_octet();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) push_text($sformatf("%0d", $urandom_range(0, 255)));
    else if (roll < 88) push_text($sformatf("0%0d", $urandom_range(0, 99)));
    else if (roll < 95) push_text($sformatf("%0d", $urandom_range(256, 999)));
    else if (roll < 97) begin
      // leave the octet empty
    end else push_text($sformatf("%0d", $urandom_range(1000, 9999)));
  endfunction

  function automatic void add_quad();
    int unsigned octets;
    octets = 4;
    if ($urandom_range(0, 99) < 6) octets = $urandom_range(0, 1) ? 3 : 5;
    for (int i = 0; i < octets; i++) begin
      if (i != 0) host_buf.push_back(ialv_pkg::CH_DOT);
      add_octet();
    end
  endfunction

  function automatic void add_groups(int unsigned count);
    int unsigned width;
    for (int i = 0; i < count; i++) begin
      if (i != 0) host_buf.push_back(ialv_pkg::CH_COLON);
      width = ($urandom_range(0, 99) < 95) ? $urandom_range(1, 4) : 5;
      for (int j = 0; j < width; j++) begin
        if ($urandom_range(0, 99) < 97) host_buf.push_back(hex_digit_char($urandom_range(0, 21)));
        else host_buf.push_back(16'($urandom_range(103, 122)));
      end
    end
  endfunction

  function automatic void add_v6();
    bit          quad_tail;
    int unsigned groups;
    int unsigned left;
    quad_tail = ($urandom_range(0, 99) < 30);
    if ($urandom_range(0, 99) < 55) begin
      // compressed form: groups on either side of one double colon
      groups = $urandom_range(0, quad_tail ? 5 : 7);
      if ($urandom_range(0, 99) < 8) groups = quad_tail ? 6 : 8;
      left = $urandom_range(0, groups);
      add_groups(left);
      host_buf.push_back(ialv_pkg::CH_COLON);
      host_buf.push_back(ialv_pkg::CH_COLON);
      add_groups(groups - left);
      if (quad_tail) begin
        if (groups != left) host_buf.push_back(ialv_pkg::CH_COLON);
        add_quad();
      end
    end else begin
      groups = quad_tail ? 6 : 8;
      if ($urandom_range(0, 99) < 10) groups = $urandom_range(1, 9);
      add_groups(groups);
      if (quad_tail) begin
        host_buf.push_back(ialv_pkg::CH_COLON);
        add_quad();
      end
    end
  endfunction

  function automatic void mutate_host();
    int unsigned pos;
    pos = $urandom_range(0, host_buf.size() - 1);
    case ($urandom_range(0, 2))
      0:       host_buf[pos] = noise_char();
      1:       if (host_buf.size() > 1) host_buf.delete(pos);
      default: host_buf.insert(pos, noise_char());
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_ipv4_literals();
    send_text("1.2.3.4");
    send_text("255.255.255.255");
    send_text("0.0.0.0");
    send_text("256.1.1.1");
    send_text("01.2.3.4");
    send_text("1.2.3");
    send_text("1.2.3.4.5");
    send_text("1..3.4");
    send_text("1234.1.1.1");
    send_text("7");
    drain_verdicts();
  endtask

  task automatic test_ipv6_literals();
    send_text("::");
    send_text(":1");
    send_text("1:");
    send_text("1:2:3:4:5:6:7:8");
    send_text("1:2:3:4:5:6:7:8:9");
    send_text("1::3:4:5:6:7:8:9");
    send_text("::ffff:10.0.0.1");
    send_text("1:2:3:4:5:6:1.2.3.4");
    send_text("ABCD:ef01::");
    send_text("12345::");
    send_text("1::2::3");
    drain_verdicts();
  endtask

  task automatic test_odd_code_units();
    // a non-ASCII code unit on its own
    host_buf.delete();
    host_buf.push_back(16'hFFFF);
    send_host();
    // a digit with a set high byte must not pass as a digit
    host_buf.delete();
    push_text("1.2.3.");
    host_buf.push_back(16'h0134);
    send_host();
    // wide colon and alternating patterns around a compression mark
    host_buf.delete();
    host_buf.push_back(16'hAAAA);
    host_buf.push_back(ialv_pkg::CH_COLON);
    host_buf.push_back(ialv_pkg::CH_COLON);
    host_buf.push_back(16'h5555);
    host_buf.push_back(16'hFF1A);
    send_host();
    drain_verdicts();
  endtask

  task automatic test_random_hosts();
    int unsigned units;
    int unsigned hosts;
    int unsigned roll;
    units = 0;
    hosts = 0;
    while (units < 200 || hosts < 10) begin
      host_buf.delete();
      roll = $urandom_range(0, 99);
      if (roll < 40) add_quad();
      else if (roll < 88) add_v6();
      else begin
        repeat ($urandom_range(1, 8)) host_buf.push_back(noise_char());
      end
      if (roll < 88 && $urandom_range(0, 99) < 15) mutate_host();
      sender_calm = ($urandom_range(0, 99) < 15);
      sink_calm   = ($urandom_range(0, 99) < 15);
      units += host_buf.size();
      hosts++;
      send_host();
      if ($urandom_range(0, 99) < 4) drain_verdicts();
    end
    drain_verdicts();
    sender_calm = 1'b0;
    sink_calm   = 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  // Random back-pressure on the verdict channel
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (sink_calm || $urandom_range(0, 99) < 70) begin
      out_stall <= 1'b0;
    end else begin
      stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(3, 39);
      out_stall  <= 1'b1;
    end
  end

  // Compare each accepted verdict with the oldest prediction
  always @(posedge clk) begin
    ialv_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict with none outstanding: is_ip_address %b, is_ipv6_form %b",
               out_data.is_ip_address, out_data.is_ipv6_form);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_data.is_ip_address !== want.is_ip_address) begin
          $error("is_ip_address: expected %b, got %b", want.is_ip_address,
                 out_data.is_ip_address);
          errors++;
        end
        if (out_data.is_ipv6_form !== want.is_ipv6_form) begin
          $error("is_ipv6_form: expected %b, got %b", want.is_ipv6_form,
                 out_data.is_ipv6_form);
          errors++;
        end
      end
    end
  end

  // Count cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    reset_tracking();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ipv4_literals();
    test_ipv6_literals();
    test_odd_code_units();
    test_random_hosts();
    // let any stray verdict show up before the final decision
    repeat (8) @(posedge clk);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
